/* rtl/tqbrr_pkg.sv */
// ----------------------------------------------------------------------------
// tqbrr_pkg
// Types and constants shared by the three-lane burst round-robin queue.
// ----------------------------------------------------------------------------
package tqbrr_pkg;

    localparam int NUM_LANES = 3;
    localparam int LANE_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int BURST_W   = 4;

    localparam logic [BURST_W-1:0] BURST_LIMIT_RESET = 4'd3;

    typedef enum logic [0:0] {
        OP_ENQUEUE = 1'b0,
        OP_SERVE   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic [LANE_W-1:0]         lane;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] served_value;
        logic [LANE_W-1:0]         served_lane;
    } out_item_t;

    // Outcome of one item, passed from the control stage to the result stage.
    typedef struct packed {
        logic              serve_ok;
        status_t           status;
        logic [LANE_W-1:0] lane;
    } result_t;

    function automatic logic [LANE_W-1:0] lane_after(input logic [LANE_W-1:0] l);
        logic [LANE_W-1:0] n;
        begin
            n = (l == LANE_W'(NUM_LANES - 1)) ? '0 : l + 1'b1;
            return n;
        end
    endfunction

endpackage

/* rtl/tqbrr_ram.sv */
// ----------------------------------------------------------------------------
// tqbrr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tqbrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tqbrr_ctrl.sv */
// ----------------------------------------------------------------------------
// tqbrr_ctrl
// Queue pointers, fill counts and the burst round-robin choice. Works on the
// registered input item and drives the lane store for at most one access per item.
// ----------------------------------------------------------------------------
module tqbrr_ctrl #(
    parameter int QUEUE_DEPTH = 128,
    parameter int ADDR_W      = $clog2(tqbrr_pkg::NUM_LANES * QUEUE_DEPTH)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   fire,
    input  tqbrr_pkg::in_item_t                    item,
    input  logic                                   cfg_we,
    input  logic [tqbrr_pkg::BURST_W-1:0]          cfg_data,
    output logic                                   ram_we,
    output logic                                   ram_re,
    output logic [ADDR_W-1:0]                      ram_addr,
    output tqbrr_pkg::result_t                     result
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int NL    = tqbrr_pkg::NUM_LANES;
    localparam int LW    = tqbrr_pkg::LANE_W;
    localparam int BW    = tqbrr_pkg::BURST_W;

    localparam logic [ADDR_W-1:0] BASE1 = ADDR_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] BASE2 = ADDR_W'(2 * QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0] rd_ptr_reg  [NL];
    logic [PTR_W-1:0] rd_ptr_next [NL];
    logic [PTR_W-1:0] wr_ptr_reg  [NL];
    logic [PTR_W-1:0] wr_ptr_next [NL];
    logic [CNT_W-1:0] count_reg   [NL];
    logic [CNT_W-1:0] count_next  [NL];
    logic [LW-1:0]    cur_lane_reg;
    logic [LW-1:0]    cur_lane_next;
    logic [BW-1:0]    burst_cnt_reg;
    logic [BW-1:0]    burst_cnt_next;
    logic [BW-1:0]    burst_limit_reg;

    logic [NL-1:0]    nonempty;
    logic             need_move;
    logic [LW-1:0]    l1;
    logic [LW-1:0]    l2;
    logic [LW-1:0]    serve_lane;
    logic             enq_lane_ok;
    logic [LW-1:0]    enq_lane;
    logic [LW-1:0]    access_lane;
    logic [PTR_W-1:0] access_ptr;
    logic [ADDR_W-1:0] lane_base;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
        end
    end

    // The burst ends on the limit or on an empty lane; the forward search
    // falls back to the current lane when it alone holds values.
    assign need_move = (burst_cnt_reg >= burst_limit_reg) || !nonempty[cur_lane_reg];
    assign l1 = tqbrr_pkg::lane_after(cur_lane_reg);
    assign l2 = tqbrr_pkg::lane_after(l1);

    always_comb
    begin
        if (!need_move)
        begin
            serve_lane = cur_lane_reg;
        end
        else if (nonempty[l1])
        begin
            serve_lane = l1;
        end
        else if (nonempty[l2])
        begin
            serve_lane = l2;
        end
        else
        begin
            serve_lane = cur_lane_reg;
        end
    end

    assign enq_lane_ok = (item.lane < LW'(NL));
    assign enq_lane    = enq_lane_ok ? item.lane : '0;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            rd_ptr_next[i] = rd_ptr_reg[i];
            wr_ptr_next[i] = wr_ptr_reg[i];
            count_next[i]  = count_reg[i];
        end
        cur_lane_next   = cur_lane_reg;
        burst_cnt_next  = burst_cnt_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        access_lane     = enq_lane;
        access_ptr      = wr_ptr_reg[enq_lane];
        result.serve_ok = 1'b0;
        result.status   = tqbrr_pkg::STATUS_DONE;
        result.lane     = '0;

        case (item.op)
            tqbrr_pkg::OP_ENQUEUE:
            begin
                if (!enq_lane_ok || count_reg[enq_lane] == CNT_FULL)
                begin
                    result.status = tqbrr_pkg::STATUS_FULL;
                end
                else
                begin
                    ram_we = fire;
                    wr_ptr_next[enq_lane] = (wr_ptr_reg[enq_lane] == PTR_LAST) ?
                                            '0 : wr_ptr_reg[enq_lane] + 1'b1;
                    count_next[enq_lane]  = count_reg[enq_lane] + 1'b1;
                end
            end
            tqbrr_pkg::OP_SERVE:
            begin
                access_lane = serve_lane;
                access_ptr  = rd_ptr_reg[serve_lane];
                if (nonempty == '0)
                begin
                    result.status = tqbrr_pkg::STATUS_EMPTY;
                end
                else
                begin
                    ram_re          = fire;
                    result.serve_ok = 1'b1;
                    result.lane     = serve_lane;
                    rd_ptr_next[serve_lane] = (rd_ptr_reg[serve_lane] == PTR_LAST) ?
                                              '0 : rd_ptr_reg[serve_lane] + 1'b1;
                    count_next[serve_lane]  = count_reg[serve_lane] - 1'b1;
                    cur_lane_next  = serve_lane;
                    burst_cnt_next = need_move ? BW'(1) : burst_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                result.status = tqbrr_pkg::STATUS_DONE;
            end
        endcase
    end

    always_comb
    begin
        case (access_lane)
            LW'(1):  lane_base = BASE1;
            LW'(2):  lane_base = BASE2;
            default: lane_base = '0;
        endcase
    end

    assign ram_addr = lane_base + ADDR_W'(access_ptr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NL; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
            cur_lane_reg    <= '0;
            burst_cnt_reg   <= '0;
            burst_limit_reg <= tqbrr_pkg::BURST_LIMIT_RESET;
        end
        else
        begin
            if (fire)
            begin
                for (int i = 0; i < NL; i++)
                begin
                    rd_ptr_reg[i] <= rd_ptr_next[i];
                    wr_ptr_reg[i] <= wr_ptr_next[i];
                    count_reg[i]  <= count_next[i];
                end
                cur_lane_reg  <= cur_lane_next;
                burst_cnt_reg <= burst_cnt_next;
            end
            if (cfg_we)
            begin
                burst_limit_reg <= cfg_data;
            end
        end
    end

endmodule

/* rtl/three_queue_burst_round_robin_top.sv */
// ----------------------------------------------------------------------------
// three_queue_burst_round_robin_top
// Three FIFO lanes of signed 32-bit values served by burst round robin.
// ----------------------------------------------------------------------------
// Each input item either enqueues a value into one lane or asks for the next
// value. Every item gives exactly one result item carrying a status, and for
// a successful serve the value and the lane it came from.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The register port writes burst_limit whenever cfg_we is high.
// An item goes through an input register, then the control stage, which
// updates pointers and counts and makes at most one access to the lane store, then
// the result register fed by the store's registered read port.
// The result is offered from the result register, after the input register.
// Throughput: one item per cycle while not stalled, set by the single port of
// the lane store, which takes the enqueue write or the serve read of an item.
// While the receiver stalls a held result, the whole pipeline holds and the
// input channel is stalled; the shown result does not change.
// Reset empties all lanes, selects lane 0, clears the burst count and sets
// burst_limit to 3. The lane store itself is not cleared.
// ----------------------------------------------------------------------------
module three_queue_burst_round_robin_top #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tqbrr_pkg::in_item_t                 in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tqbrr_pkg::out_item_t                out_item,
    input  logic                                cfg_we,
    input  logic [tqbrr_pkg::BURST_W-1:0]       cfg_data
);

    localparam int ADDR_W = $clog2(tqbrr_pkg::NUM_LANES * QUEUE_DEPTH);

    logic                            advance;
    logic                            fire;
    logic                            in_valid_reg;
    tqbrr_pkg::in_item_t             in_item_reg;
    logic                            out_valid_reg;
    tqbrr_pkg::result_t              result;
    tqbrr_pkg::result_t              result_reg;
    logic                            ram_we;
    logic                            ram_re;
    logic [ADDR_W-1:0]               ram_addr;
    logic [tqbrr_pkg::VALUE_W-1:0]   ram_rdata;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= in_valid;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_item_reg <= in_item;
            result_reg  <= result;
        end
    end

    tqbrr_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (in_item_reg),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .ram_we   (ram_we),
        .ram_re   (ram_re),
        .ram_addr (ram_addr),
        .result   (result)
    );

    tqbrr_ram #(
        .WIDTH (tqbrr_pkg::VALUE_W),
        .DEPTH (tqbrr_pkg::NUM_LANES * QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (in_item_reg.value),
        .rdata (ram_rdata)
    );

    assign out_valid             = out_valid_reg;
    assign out_item.status       = result_reg.status;
    assign out_item.served_value = result_reg.serve_ok ? ram_rdata : '0;
    assign out_item.served_lane  = result_reg.lane;

endmodule

/* rtl/tqbrr_checker.sv */
// ----------------------------------------------------------------------------
// tqbrr_checker
// Port-level checks on the burst round-robin queue, bound to the top level.
// ----------------------------------------------------------------------------
module tqbrr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input tqbrr_pkg::in_item_t           in_item,
    input logic                          out_valid,
    input logic                          out_stall,
    input tqbrr_pkg::out_item_t          out_item
);

    // A held result stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

    // A stalled input item is held by the sender.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

    // Every accepted item is followed by a result on the port once it has passed the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 out_valid)
    else $error("result missing after accepted item");

    // Only a successful serve carries a value or a lane.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != tqbrr_pkg::STATUS_DONE |->
        out_item.served_value == '0 && out_item.served_lane == '0)
    else $error("failed item carries a value or lane");

    // A served lane is always one of the three real lanes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.served_lane != 2'd3)
    else $error("served lane out of range");

endmodule

bind three_queue_burst_round_robin_top tqbrr_checker u_tqbrr_checker (.*);
